// ===== rtl/sha_pkg.sv =====
// Shared types and constants for the slot handle allocator.
package sha_pkg;

  localparam int unsigned SLOTS     = 256;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned FLAG_W    = 8;

  localparam logic [FLAG_W-1:0] ACTIVE_FLAG = FLAG_W'(1);
  localparam logic [FLAG_W-1:0] DIRTY_FLAG  = FLAG_W'(2);

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_GET    = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_INACTIVE = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } stat_t;

endpackage

// ===== rtl/sha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sha_ctrl.sv =====
// Controller state machine: sequences capture and commit of one item.
module sha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sha_pkg::stat_t stat_i,
  output sha_pkg::cmd_t  cmd_o
);

  sha_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      sha_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sha_pkg::S_EXEC;
        end
      end
      sha_pkg::S_EXEC: begin
        if (!stat_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d      = sha_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sha_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sha_datapath.sv =====
// Datapath: slot memories, free stack, counters and result register.
module sha_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sha_pkg::cmd_t                   cmd_i,
  output sha_pkg::stat_t                  stat_o,
  input  logic [1:0]                      mode_i,
  input  logic [sha_pkg::ADDR_W-1:0]      handle_in_i,
  input  logic [sha_pkg::PAYLOAD_W-1:0]   payload_in_i,
  input  logic [sha_pkg::FLAG_W-1:0]      flags_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic [sha_pkg::ADDR_W-1:0]      handle_out_o,
  output logic [sha_pkg::PAYLOAD_W-1:0]   payload_out_o,
  output logic [sha_pkg::FLAG_W-1:0]      flags_out_o,
  output logic [sha_pkg::CNT_W-1:0]       capacity_o,
  output logic [sha_pkg::CNT_W-1:0]       live_count_out_o
);

  localparam logic [sha_pkg::CNT_W-1:0] SlotsC = sha_pkg::CNT_W'(sha_pkg::SLOTS);

  // captured item
  logic [1:0]                    mode_q;
  logic [sha_pkg::ADDR_W-1:0]    hin_q;
  logic [sha_pkg::PAYLOAD_W-1:0] pin_q;
  logic [sha_pkg::FLAG_W-1:0]    fin_q;

  // counters
  logic [sha_pkg::CNT_W-1:0] free_top_q, free_top_d;
  logic [sha_pkg::CNT_W-1:0] hw_q, hw_d;
  logic [sha_pkg::CNT_W-1:0] live_q, live_d;

  // result register
  logic                          out_valid_q;
  logic [1:0]                    status_q, status_d;
  logic [sha_pkg::ADDR_W-1:0]    handle_q, handle_d;
  logic [sha_pkg::PAYLOAD_W-1:0] payload_q, payload_d;
  logic [sha_pkg::FLAG_W-1:0]    flags_q, flags_d;
  logic [sha_pkg::CNT_W-1:0]     cap_q, livo_q;

  // memory ports
  logic [sha_pkg::PAYLOAD_W-1:0] pay_rdata;
  logic [sha_pkg::FLAG_W-1:0]    flag_rdata;
  logic [sha_pkg::ADDR_W-1:0]    stk_rdata;
  logic [sha_pkg::CNT_W-1:0]     stk_top_m1;
  logic                          pay_we, flag_we, stk_we;
  logic [sha_pkg::ADDR_W-1:0]    slot_waddr;
  logic [sha_pkg::FLAG_W-1:0]    flag_wdata;

  assign stk_top_m1 = free_top_q - sha_pkg::CNT_W'(1);

  sha_ram #(.WIDTH(sha_pkg::PAYLOAD_W), .DEPTH(sha_pkg::SLOTS)) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (slot_waddr),
    .wdata_i (pin_q),
    .re_i    (cmd_i.capture),
    .raddr_i (handle_in_i),
    .rdata_o (pay_rdata)
  );

  sha_ram #(.WIDTH(sha_pkg::FLAG_W), .DEPTH(sha_pkg::SLOTS)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (slot_waddr),
    .wdata_i (flag_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (handle_in_i),
    .rdata_o (flag_rdata)
  );

  sha_ram #(.WIDTH(sha_pkg::ADDR_W), .DEPTH(sha_pkg::SLOTS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (free_top_q[sha_pkg::ADDR_W-1:0]),
    .wdata_i (hin_q),
    .re_i    (cmd_i.capture),
    .raddr_i (stk_top_m1[sha_pkg::ADDR_W-1:0]),
    .rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      hin_q  <= handle_in_i;
      pin_q  <= payload_in_i;
      fin_q  <= flags_in_i;
    end
  end

  always_comb begin
    free_top_d = free_top_q;
    hw_d       = hw_q;
    live_d     = live_q;
    status_d   = sha_pkg::ST_OK;
    handle_d   = hin_q;
    payload_d  = '0;
    flags_d    = '0;
    pay_we     = 1'b0;
    flag_we    = 1'b0;
    stk_we     = 1'b0;
    slot_waddr = hin_q;
    flag_wdata = '0;
    case (sha_pkg::mode_e'(mode_q))
      sha_pkg::MODE_ADD: begin
        if (free_top_q != '0 || hw_q < SlotsC) begin
          if (free_top_q != '0) begin
            free_top_d = stk_top_m1;
            slot_waddr = stk_rdata;
          end else begin
            slot_waddr = hw_q[sha_pkg::ADDR_W-1:0];
            hw_d       = hw_q + sha_pkg::CNT_W'(1);
          end
          flag_wdata = fin_q | sha_pkg::ACTIVE_FLAG | sha_pkg::DIRTY_FLAG;
          pay_we     = 1'b1;
          flag_we    = 1'b1;
          if (live_q < SlotsC) begin
            live_d = live_q + sha_pkg::CNT_W'(1);
          end
          handle_d = slot_waddr;
          flags_d  = flag_wdata;
        end else begin
          status_d = sha_pkg::ST_FULL;
          handle_d = '0;
        end
      end
      sha_pkg::MODE_REMOVE, sha_pkg::MODE_GET: begin
        if ({1'b0, hin_q} >= hw_q) begin
          status_d = sha_pkg::ST_RANGE;
        end else if ((flag_rdata & sha_pkg::ACTIVE_FLAG) == '0) begin
          status_d = sha_pkg::ST_INACTIVE;
        end else if (mode_q == sha_pkg::MODE_REMOVE) begin
          flag_we = 1'b1;
          if (free_top_q < SlotsC) begin
            stk_we     = 1'b1;
            free_top_d = free_top_q + sha_pkg::CNT_W'(1);
          end
          if (live_q != '0) begin
            live_d = live_q - sha_pkg::CNT_W'(1);
          end
        end else begin
          payload_d = pay_rdata;
          flags_d   = flag_rdata;
        end
      end
      default: begin
      end
    endcase
    if (!cmd_i.commit) begin
      pay_we  = 1'b0;
      flag_we = 1'b0;
      stk_we  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q  <= '0;
      hw_q        <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        free_top_q  <= free_top_d;
        hw_q        <= hw_d;
        live_q      <= live_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q  <= status_d;
      handle_q  <= handle_d;
      payload_q <= payload_d;
      flags_q   <= flags_d;
      cap_q     <= hw_d;
      livo_q    <= live_d;
    end
  end

  assign stat_o.out_blocked = out_valid_q & ~out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign handle_out_o     = handle_q;
  assign payload_out_o    = payload_q;
  assign flags_out_o      = flags_q;
  assign capacity_o       = cap_q;
  assign live_count_out_o = livo_q;

endmodule

// ===== rtl/slot_handle_allocator_top.sv =====
// Top level of the slot handle allocator.
//
// Input channel (in_valid_i / in_ready_o) carries one operation per item:
// mode_i selects add, remove, get or nop; handle_in_i, payload_in_i and
// flags_in_i are its operands. Output channel (out_valid_o / out_ready_i)
// returns exactly one result item per operation, in order, with status,
// handle, payload, flags, high-water capacity and live count.
//
// Each item passes through an accept step and an evaluate step: the accept
// cycle launches reads of the payload, flag and free-stack RAMs, then the
// evaluate step computes the result, writes the RAMs and loads the output
// register. The registered RAM read is why evaluation is a separate step.
// A new item is accepted only after the previous one has been committed.
//
// The output register holds a finished result while the next item is
// accepted. If the receiver stalls, the following item waits in the
// evaluate step until the output register frees up.
//
// Reset clears the free-stack top, high-water mark, live count and output valid flag; the
// slot memories need no clearing since no slot is read before written.
module slot_handle_allocator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      mode_i,
  input  logic [sha_pkg::ADDR_W-1:0]      handle_in_i,
  input  logic [sha_pkg::PAYLOAD_W-1:0]   payload_in_i,
  input  logic [sha_pkg::FLAG_W-1:0]      flags_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic [sha_pkg::ADDR_W-1:0]      handle_out_o,
  output logic [sha_pkg::PAYLOAD_W-1:0]   payload_out_o,
  output logic [sha_pkg::FLAG_W-1:0]      flags_out_o,
  output logic [sha_pkg::CNT_W-1:0]       capacity_o,
  output logic [sha_pkg::CNT_W-1:0]       live_count_out_o
);

  sha_pkg::cmd_t  cmd;
  sha_pkg::stat_t stat;

  sha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sha_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .mode_i           (mode_i),
    .handle_in_i      (handle_in_i),
    .payload_in_i     (payload_in_i),
    .flags_in_i       (flags_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .handle_out_o     (handle_out_o),
    .payload_out_o    (payload_out_o),
    .flags_out_o      (flags_out_o),
    .capacity_o       (capacity_o),
    .live_count_out_o (live_count_out_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  a_cap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (capacity_o <= sha_pkg::CNT_W'(sha_pkg::SLOTS)))
    else $error("capacity above slot count");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (live_count_out_o <= capacity_o))
    else $error("live count above capacity");

  a_full_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == sha_pkg::ST_FULL) |->
      (capacity_o == sha_pkg::CNT_W'(sha_pkg::SLOTS) && live_count_out_o == capacity_o))
    else $error("store full reported below capacity");

endmodule

// ===== bench/tb.sv =====
// Testbench for slot_handle_allocator_top: directed table plus random ops checked by a predictor.
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int SEG_ITEMS   = 175;
  localparam int DRAIN_ITEMS = 300;
  localparam int FULL_TARGET = 8;
  localparam int FILL_MAX    = 600;

  typedef struct packed {
    sha_pkg::status_e              status;
    logic [sha_pkg::ADDR_W-1:0]    handle;
    logic [sha_pkg::PAYLOAD_W-1:0] payload;
    logic [sha_pkg::FLAG_W-1:0]    flags;
    logic [sha_pkg::CNT_W-1:0]     cap;
    logic [sha_pkg::CNT_W-1:0]     live;
  } result_t;

  typedef struct packed {
    sha_pkg::mode_e                mode;
    logic [sha_pkg::ADDR_W-1:0]    h;
    logic [sha_pkg::PAYLOAD_W-1:0] p;
    logic [sha_pkg::FLAG_W-1:0]    f;
    logic                          fixed;
    result_t                       want;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{sha_pkg::MODE_GET,    8'h00, 32'h0,        8'h00, 1'b1,
      '{sha_pkg::ST_RANGE,    8'h00, 32'h0,        8'h00, 9'd0, 9'd0}},
    '{sha_pkg::MODE_REMOVE, 8'hFF, 32'h0,        8'h00, 1'b1,
      '{sha_pkg::ST_RANGE,    8'hFF, 32'h0,        8'h00, 9'd0, 9'd0}},
    '{sha_pkg::MODE_NOP,    8'hFF, 32'hFFFFFFFF, 8'hFF, 1'b1,
      '{sha_pkg::ST_OK,       8'hFF, 32'h0,        8'h00, 9'd0, 9'd0}},
    '{sha_pkg::MODE_ADD,    8'h7F, 32'hFFFFFFFF, 8'h00, 1'b1,
      '{sha_pkg::ST_OK,       8'h00, 32'h0,        8'h03, 9'd1, 9'd1}},
    '{sha_pkg::MODE_ADD,    8'h00, 32'h0,        8'hFF, 1'b1,
      '{sha_pkg::ST_OK,       8'h01, 32'h0,        8'hFF, 9'd2, 9'd2}},
    '{sha_pkg::MODE_GET,    8'h00, 32'h0,        8'h00, 1'b1,
      '{sha_pkg::ST_OK,       8'h00, 32'hFFFFFFFF, 8'h03, 9'd2, 9'd2}},
    '{sha_pkg::MODE_GET,    8'h01, 32'h0,        8'h00, 1'b1,
      '{sha_pkg::ST_OK,       8'h01, 32'h0,        8'hFF, 9'd2, 9'd2}},
    '{sha_pkg::MODE_REMOVE, 8'h00, 32'h0,        8'h00, 1'b1,
      '{sha_pkg::ST_OK,       8'h00, 32'h0,        8'h00, 9'd2, 9'd1}},
    '{sha_pkg::MODE_GET,    8'h00, 32'h0,        8'h00, 1'b1,
      '{sha_pkg::ST_INACTIVE, 8'h00, 32'h0,        8'h00, 9'd2, 9'd1}},
    '{sha_pkg::MODE_REMOVE, 8'h00, 32'h0,        8'h00, 1'b1,
      '{sha_pkg::ST_INACTIVE, 8'h00, 32'h0,        8'h00, 9'd2, 9'd1}},
    '{sha_pkg::MODE_GET,    8'h02, 32'h0,        8'h00, 1'b1,
      '{sha_pkg::ST_RANGE,    8'h02, 32'h0,        8'h00, 9'd2, 9'd1}},
    '{sha_pkg::MODE_ADD,    8'h80, 32'hA5A55A5A, 8'h80, 1'b0, '0},
    '{sha_pkg::MODE_REMOVE, 8'h01, 32'h0,        8'h00, 1'b0, '0},
    '{sha_pkg::MODE_REMOVE, 8'h00, 32'h0,        8'h00, 1'b0, '0},
    '{sha_pkg::MODE_ADD,    8'h00, 32'h00001234, 8'h55, 1'b0, '0},
    '{sha_pkg::MODE_ADD,    8'h00, 32'h00005678, 8'hAA, 1'b0, '0},
    '{sha_pkg::MODE_ADD,    8'h00, 32'h80000001, 8'h7C, 1'b0, '0},
    '{sha_pkg::MODE_GET,    8'h02, 32'h0,        8'h00, 1'b0, '0},
    '{sha_pkg::MODE_NOP,    8'h00, 32'h12345678, 8'h0F, 1'b0, '0},
    '{sha_pkg::MODE_REMOVE, 8'h02, 32'h0,        8'h00, 1'b0, '0},
    '{sha_pkg::MODE_GET,    8'h02, 32'h0,        8'h00, 1'b0, '0},
    '{sha_pkg::MODE_GET,    8'hFF, 32'h0,        8'h00, 1'b1,
      '{sha_pkg::ST_RANGE,    8'hFF, 32'h0,        8'h00, 9'd3, 9'd2}}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [1:0]                    mode_i;
  logic [sha_pkg::ADDR_W-1:0]    handle_in_i;
  logic [sha_pkg::PAYLOAD_W-1:0] payload_in_i;
  logic [sha_pkg::FLAG_W-1:0]    flags_in_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [1:0]                    status_o;
  logic [sha_pkg::ADDR_W-1:0]    handle_out_o;
  logic [sha_pkg::PAYLOAD_W-1:0] payload_out_o;
  logic [sha_pkg::FLAG_W-1:0]    flags_out_o;
  logic [sha_pkg::CNT_W-1:0]     capacity_o;
  logic [sha_pkg::CNT_W-1:0]     live_count_out_o;

  // typed expectation travelling with the item on the input channel
  logic    row_fixed;
  result_t row_want;

  // predictor state
  logic [sha_pkg::PAYLOAD_W-1:0] slot_pay  [sha_pkg::SLOTS];
  logic [sha_pkg::FLAG_W-1:0]    slot_flg  [sha_pkg::SLOTS];
  logic [sha_pkg::ADDR_W-1:0]    free_list [sha_pkg::SLOTS];
  int                            free_cnt;
  int                            hw_mark;
  int                            live_cnt;
  int                            full_hits;

  result_t result_q [$];
  int      err_cnt;
  int      quiet_cnt;
  int      send_idle_pct;
  int      recv_stall_pct;

  slot_handle_allocator_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .handle_in_i      (handle_in_i),
    .payload_in_i     (payload_in_i),
    .flags_in_i       (flags_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .handle_out_o     (handle_out_o),
    .payload_out_o    (payload_out_o),
    .flags_out_o      (flags_out_o),
    .capacity_o       (capacity_o),
    .live_count_out_o (live_count_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic result_t slot_op(sha_pkg::mode_e m, logic [sha_pkg::ADDR_W-1:0] h,
                                      logic [sha_pkg::PAYLOAD_W-1:0] p,
                                      logic [sha_pkg::FLAG_W-1:0] f);
    result_t r;
    int      s;
    r = '0;
    r.status = sha_pkg::ST_OK;
    r.handle = h;
    case (m)
      sha_pkg::MODE_ADD: begin
        s = -1;
        if (free_cnt > 0) begin
          free_cnt--;
          s = free_list[free_cnt];
        end else if (hw_mark < sha_pkg::SLOTS) begin
          s = hw_mark;
          hw_mark++;
        end
        if (s < 0) begin
          r.status = sha_pkg::ST_FULL;
          r.handle = '0;
          full_hits++;
        end else begin
          slot_pay[s] = p;
          slot_flg[s] = f | sha_pkg::ACTIVE_FLAG | sha_pkg::DIRTY_FLAG;
          if (live_cnt < sha_pkg::SLOTS) live_cnt++;
          r.handle = s[sha_pkg::ADDR_W-1:0];
          r.flags  = slot_flg[s];
        end
      end
      sha_pkg::MODE_NOP: ;
      default: begin
        if (h >= hw_mark) begin
          r.status = sha_pkg::ST_RANGE;
        end else if ((slot_flg[h] & sha_pkg::ACTIVE_FLAG) == '0) begin
          r.status = sha_pkg::ST_INACTIVE;
        end else if (m == sha_pkg::MODE_REMOVE) begin
          slot_flg[h] = '0;
          if (free_cnt < sha_pkg::SLOTS) begin
            free_list[free_cnt] = h;
            free_cnt++;
          end
          if (live_cnt > 0) live_cnt--;
        end else begin
          r.payload = slot_pay[h];
          r.flags   = slot_flg[h];
        end
      end
    endcase
    r.cap  = hw_mark[sha_pkg::CNT_W-1:0];
    r.live = live_cnt[sha_pkg::CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(string nm, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, want, got);
    end
  endtask

  // input acceptance feeds the predictor; output acceptance is checked in order
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want = slot_op(sha_pkg::mode_e'(mode_i), handle_in_i, payload_in_i, flags_in_i);
        if (row_fixed) want = row_want;
        result_q.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result item, status %0d handle %h", $time,
                   status_o, handle_out_o);
        end else begin
          want = result_q.pop_front();
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("handle", 32'(want.handle), 32'(handle_out_o));
          check_field("payload", want.payload, payload_out_o);
          check_field("flags", 32'(want.flags), 32'(flags_out_o));
          check_field("capacity", 32'(want.cap), 32'(capacity_o));
          check_field("live_count", 32'(want.live), 32'(live_count_out_o));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cnt = 0;
      end else begin
        quiet_cnt++;
        if (quiet_cnt >= QUIET_LIMIT) begin
          $display("%0t: timeout, %0d results outstanding", $time, result_q.size());
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_op(sha_pkg::mode_e m, logic [sha_pkg::ADDR_W-1:0] h,
                         logic [sha_pkg::PAYLOAD_W-1:0] p,
                         logic [sha_pkg::FLAG_W-1:0] f, logic fixed, result_t want);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    handle_in_i  <= h;
    payload_in_i <= p;
    flags_in_i   <= f;
    row_fixed    <= fixed;
    row_want     <= want;
    // ready is stable from the falling edge until the next rising edge
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [sha_pkg::ADDR_W-1:0] pick_handle();
    int k;
    int c;
    int t;
    k = $urandom_range(99);
    if (k < 15 || hw_mark == 0) return sha_pkg::ADDR_W'($urandom_range(255));
    if (k < 30) return sha_pkg::ADDR_W'($urandom_range(hw_mark > 255 ? 255 : hw_mark));
    c = $urandom_range(hw_mark - 1);
    for (t = 0; t < 8 && (slot_flg[c] & sha_pkg::ACTIVE_FLAG) == '0; t++)
      c = $urandom_range(hw_mark - 1);
    return c[sha_pkg::ADDR_W-1:0];
  endfunction

  initial begin
    int             n;
    int             drained;
    int             r;
    bit             filling;
    sha_pkg::mode_e m;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    mode_i         <= sha_pkg::MODE_NOP;
    handle_in_i    <= '0;
    payload_in_i   <= '0;
    flags_in_i     <= '0;
    row_fixed      <= 1'b0;
    row_want       <= '0;
    free_cnt       = 0;
    hw_mark        = 0;
    live_cnt       = 0;
    full_hits      = 0;
    err_cnt        = 0;
    quiet_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < DIR_ROWS; n++)
      send_op(DIR_TAB[n].mode, DIR_TAB[n].h, DIR_TAB[n].p, DIR_TAB[n].f,
              DIR_TAB[n].fixed, DIR_TAB[n].want);

    // fill until the store has overflowed FULL_TARGET times or FILL_MAX items are sent, then churn and drain
    n = 0;
    drained = 0;
    while (drained < DRAIN_ITEMS) begin
      if (n % SEG_ITEMS == 0) begin
        drain_wait();
        case ((n / SEG_ITEMS) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
          default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
      end
      filling = (full_hits < FULL_TARGET) && (n < FILL_MAX);
      r = $urandom_range(99);
      if (filling)
        m = (r < 75) ? sha_pkg::MODE_ADD : (r < 87) ? sha_pkg::MODE_REMOVE :
            (r < 97) ? sha_pkg::MODE_GET : sha_pkg::MODE_NOP;
      else
        m = (r < 25) ? sha_pkg::MODE_ADD : (r < 65) ? sha_pkg::MODE_REMOVE :
            (r < 93) ? sha_pkg::MODE_GET : sha_pkg::MODE_NOP;
      send_op(m, pick_handle(), $urandom, sha_pkg::FLAG_W'($urandom_range(255)), 1'b0, '0);
      n++;
      if (!filling) drained++;
    end

    drain_wait();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sha_pkg.sv
rtl/sha_ram.sv
rtl/sha_ctrl.sv
rtl/sha_datapath.sv
rtl/slot_handle_allocator_top.sv
bench/tb.sv
